>>> hdl/sorted_alarm_timer_queue_unit_defines.svh
// ----------------------------------------------------------------------------
// Sorted alarm timer queue: assertion macros
// Shared wrappers that clock every property on clk_i and mute it in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_ALARM_TIMER_QUEUE_UNIT_DEFINES_SVH
`define SORTED_ALARM_TIMER_QUEUE_UNIT_DEFINES_SVH

// A condition that must hold at every clock edge.
`define SATQ_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define SATQ_ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define SATQ_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> hdl/satq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted alarm timer queue package
// Widths, operation and result codes, cell commands and shared types.
// ----------------------------------------------------------------------------
package satq_pkg;

  // Field widths of the words on both channels.
  localparam int unsigned OpW   = 3;
  localparam int unsigned KindW = 2;
  localparam int unsigned SessW = 32;
  localparam int unsigned TimeW = 64;

  // Default number of queue slots.
  localparam int unsigned QueueDepth = 16;

  // A single tick rings at most this many alarms.
  localparam int unsigned MaxRings  = 16;
  localparam int unsigned RingCntW  = $clog2(MaxRings);

  // Operation codes of an input word.
  typedef enum logic [OpW-1:0] {
    OP_TICK     = 3'd0,
    OP_WAIT_REL = 3'd1,
    OP_WAIT_ABS = 3'd2,
    OP_CANCEL   = 3'd3,
    OP_TIME     = 3'd4
  } op_e;

  // Kinds of an output word.
  typedef enum logic [KindW-1:0] {
    KIND_RING   = 2'd0,
    KIND_TIME   = 2'd1,
    KIND_REJECT = 2'd2
  } kind_e;

  // Command broadcast to every cell of the queue.
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_POP    = 2'd2
  } cell_cmd_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_INSERT = 3'd1,
    ST_CANCEL = 3'd2,
    ST_TICK   = 3'd3,
    ST_FLUSH  = 3'd4,
    ST_REPLY  = 3'd5
  } state_e;

  // One queue slot as seen by its neighbors.
  typedef struct packed {
    logic             occ;
    logic             valid;
    logic [SessW-1:0] sess;
    logic [TimeW-1:0] due;
  } entry_t;

  // Control word shared by all cells.
  typedef struct packed {
    cell_cmd_e        cmd;
    logic [SessW-1:0] sess;
    logic [TimeW-1:0] due;
  } cell_ctl_t;

  localparam entry_t EmptyEntry = '{occ: 1'b0, valid: 1'b0, sess: '0, due: '0};

endpackage

>>> hdl/satq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted alarm timer queue channels
// Request and response channels with valid/ready handshake and payload.
// ----------------------------------------------------------------------------

// Request channel: one operation word per handshake.
interface satq_in_if;
  logic                       valid;
  logic                       ready;
  logic [satq_pkg::OpW-1:0]   operation;
  logic [satq_pkg::SessW-1:0] session_id;
  logic [satq_pkg::TimeW-1:0] time_value;
  logic [satq_pkg::TimeW-1:0] current_time;

  modport source (output valid, operation, session_id, time_value, current_time,
                  input ready);
  modport sink   (input valid, operation, session_id, time_value, current_time,
                  output ready);
endinterface

// Response channel: one result word per handshake.
interface satq_out_if;
  logic                       valid;
  logic                       ready;
  logic [satq_pkg::KindW-1:0] kind;
  logic [satq_pkg::SessW-1:0] session_id_out;
  logic [satq_pkg::TimeW-1:0] time_out;
  logic                       last;

  modport source (output valid, kind, session_id_out, time_out, last, input ready);
  modport sink   (input valid, kind, session_id_out, time_out, last, output ready);
endinterface

>>> hdl/sorted_alarm_timer_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted alarm timer queue unit
// Alarm queue sorted by due time, built as a row of slot cells.
// ----------------------------------------------------------------------------
//  Channel  Dir  Word                                          Handshake
//  req_i    in   operation, session_id, time_value, current_time valid/ready
//  rsp_o    out  kind, session_id_out, time_out, last           valid/ready
//
//  Steps per word: a time request or rejected wait passes to the reply state
//  and waits there for the output; an insert passes through the insert state;
//  cancel lasts while the token walks down the cell row; a tick pops cell 0
//  once a cycle unless a stalled output holds a ring, then hands over the last
//  ring in the flush state. One word is in work at a time; a finished result
//  waits in the output register while the next word is taken. Reset is
//  asynchronous, active low, and leaves the queue empty with no clearing
//  pass. A stalled output holds a tick at its next ring.
// ----------------------------------------------------------------------------
`include "sorted_alarm_timer_queue_unit_defines.svh"

module sorted_alarm_timer_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = satq_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  satq_in_if.sink           req_i,
  satq_out_if.source        rsp_o
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH);

  satq_pkg::state_e             state_q, state_d;
  satq_pkg::cell_ctl_t          ctl;
  satq_pkg::entry_t             cell_w [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]       occ_w;
  logic [QUEUE_DEPTH-1:0]       occ_below_w;
  logic [QUEUE_DEPTH-1:0]       le_w;
  logic [QUEUE_DEPTH-1:0]       token_w;

  logic                         in_acc;
  logic                         full;
  logic                         cancel_start;
  logic [satq_pkg::TimeW-1:0]   due_w;

  // Word registers.
  logic [satq_pkg::SessW-1:0]   sess_q;
  logic [satq_pkg::TimeW-1:0]   time_q;
  logic [satq_pkg::TimeW-1:0]   due_q;
  satq_pkg::kind_e              rep_kind_q;

  // Tick and cancel bookkeeping.
  logic [satq_pkg::RingCntW-1:0] ring_cnt_q;
  logic                          ring_inc;
  logic [CntW-1:0]               cancel_cnt_q;
  logic                          pend_q;
  logic [satq_pkg::SessW-1:0]    pend_sess_q;
  logic                          pend_set, pend_clr;
  logic                          due_now;

  // Output register.
  logic                          out_valid_q;
  satq_pkg::kind_e               out_kind_q, out_kind_d;
  logic [satq_pkg::SessW-1:0]    out_sess_q, out_sess_d;
  logic [satq_pkg::TimeW-1:0]    out_time_q, out_time_d;
  logic                          out_last_q, out_last_d;
  logic                          out_ld;
  logic                          can_load;

  // Channel handshakes.
  assign req_i.ready          = (state_q == satq_pkg::ST_IDLE);
  assign in_acc               = req_i.valid && req_i.ready;
  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.kind           = out_kind_q;
  assign rsp_o.session_id_out = out_sess_q;
  assign rsp_o.time_out       = out_time_q;
  assign rsp_o.last           = out_last_q;
  assign can_load             = !out_valid_q || rsp_o.ready;

  // The top cell is occupied only when every slot is.
  assign full = occ_w[QUEUE_DEPTH-1];

  // Due time of a wait: relative waits wrap modulo 2^64.
  assign due_w = (req_i.operation == satq_pkg::OP_WAIT_REL) ?
                 req_i.current_time + req_i.time_value : req_i.time_value;

  // Cell row, due end at cell 0.
  for (genvar j = 0; j < QUEUE_DEPTH; j++) begin : g_cell
    satq_pkg::entry_t lower_w;
    satq_pkg::entry_t upper_w;
    logic             lower_le_w;
    logic             token_in_w;

    if (j == 0) begin : g_bottom
      assign lower_w    = satq_pkg::EmptyEntry;
      assign lower_le_w = 1'b1;
    end else begin : g_inner_low
      assign lower_w    = cell_w[j-1];
      assign lower_le_w = le_w[j-1];
    end

    if (j == QUEUE_DEPTH - 1) begin : g_top
      assign upper_w    = satq_pkg::EmptyEntry;
      assign token_in_w = cancel_start;
    end else begin : g_inner_high
      assign upper_w    = cell_w[j+1];
      assign token_in_w = token_w[j+1];
    end

    satq_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .lower_i    (lower_w),
      .lower_le_i (lower_le_w),
      .upper_i    (upper_w),
      .token_i    (token_in_w),
      .entry_o    (cell_w[j]),
      .le_o       (le_w[j]),
      .token_o    (token_w[j])
    );

    assign occ_w[j] = cell_w[j].occ;
  end

  assign occ_below_w = {occ_w[QUEUE_DEPTH-2:0], 1'b1};

  // The alarm at the due end has come due.
  assign due_now = cell_w[0].due <= time_q;

  // Next state, cell command and output loads.
  always_comb begin
    state_d      = state_q;
    ctl.cmd      = satq_pkg::CELL_HOLD;
    ctl.sess     = sess_q;
    ctl.due      = due_q;
    cancel_start = 1'b0;
    pend_set     = 1'b0;
    pend_clr     = 1'b0;
    ring_inc     = 1'b0;
    out_ld       = 1'b0;
    out_kind_d   = satq_pkg::KIND_RING;
    out_sess_d   = pend_sess_q;
    out_time_d   = time_q;
    out_last_d   = 1'b0;
    case (state_q)
      satq_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (req_i.operation)
            satq_pkg::OP_TICK: state_d = satq_pkg::ST_TICK;
            satq_pkg::OP_WAIT_REL, satq_pkg::OP_WAIT_ABS: begin
              state_d = full ? satq_pkg::ST_REPLY : satq_pkg::ST_INSERT;
            end
            satq_pkg::OP_CANCEL: begin
              state_d      = satq_pkg::ST_CANCEL;
              cancel_start = 1'b1;
            end
            satq_pkg::OP_TIME: state_d = satq_pkg::ST_REPLY;
            default: state_d = satq_pkg::ST_IDLE;
          endcase
        end
      end
      satq_pkg::ST_INSERT: begin
        ctl.cmd = satq_pkg::CELL_INSERT;
        state_d = satq_pkg::ST_IDLE;
      end
      satq_pkg::ST_CANCEL: begin
        if (cancel_cnt_q == '0) begin
          state_d = satq_pkg::ST_IDLE;
        end
      end
      satq_pkg::ST_TICK: begin
        if (!cell_w[0].occ || (cell_w[0].valid && !due_now)) begin
          state_d = pend_q ? satq_pkg::ST_FLUSH : satq_pkg::ST_IDLE;
        end else if (!cell_w[0].valid) begin
          // Cancelled alarm at the due end: drop it silently.
          ctl.cmd = satq_pkg::CELL_POP;
        end else if (!pend_q || can_load) begin
          // Ring the due alarm; the one held before it was not the last.
          ctl.cmd  = satq_pkg::CELL_POP;
          out_ld   = pend_q;
          pend_set = 1'b1;
          ring_inc = 1'b1;
          if (ring_cnt_q == satq_pkg::RingCntW'(satq_pkg::MaxRings - 1)) begin
            state_d = satq_pkg::ST_FLUSH;
          end
        end
      end
      satq_pkg::ST_FLUSH: begin
        if (can_load) begin
          out_ld     = 1'b1;
          out_last_d = 1'b1;
          pend_clr   = 1'b1;
          state_d    = satq_pkg::ST_IDLE;
        end
      end
      satq_pkg::ST_REPLY: begin
        if (can_load) begin
          out_ld     = 1'b1;
          out_kind_d = rep_kind_q;
          out_sess_d = sess_q;
          out_time_d = (rep_kind_q == satq_pkg::KIND_TIME) ? time_q : '0;
          out_last_d = 1'b1;
          state_d    = satq_pkg::ST_IDLE;
        end
      end
      default: state_d = satq_pkg::ST_IDLE;
    endcase
  end

  // State, counters and valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= satq_pkg::ST_IDLE;
      ring_cnt_q   <= '0;
      cancel_cnt_q <= '0;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        ring_cnt_q <= '0;
      end else if (ring_inc) begin
        ring_cnt_q <= ring_cnt_q + 1'b1;
      end
      if (cancel_start) begin
        cancel_cnt_q <= CntW'(QUEUE_DEPTH - 1);
      end else if (state_q == satq_pkg::ST_CANCEL) begin
        cancel_cnt_q <= cancel_cnt_q - 1'b1;
      end
      if (pend_set) begin
        pend_q <= 1'b1;
      end else if (pend_clr) begin
        pend_q <= 1'b0;
      end
      if (out_ld) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Word and result payload.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sess_q     <= req_i.session_id;
      time_q     <= req_i.current_time;
      due_q      <= due_w;
      rep_kind_q <= (req_i.operation == satq_pkg::OP_TIME) ?
                    satq_pkg::KIND_TIME : satq_pkg::KIND_REJECT;
    end
    if (pend_set) begin
      pend_sess_q <= cell_w[0].sess;
    end
    if (out_ld) begin
      out_kind_q <= out_kind_d;
      out_sess_q <= out_sess_d;
      out_time_q <= out_time_d;
      out_last_q <= out_last_d;
    end
  end

  // Checks on the queue and the controller.
  `SATQ_ASSERT_ALWAYS(a_occ_packed, (occ_w & ~occ_below_w) == '0, "occupied slots not packed")
  `SATQ_ASSERT_IMPL(a_idle_no_pend, state_q == satq_pkg::ST_IDLE, !pend_q, "ring held in idle")
  `SATQ_ASSERT_IMPL(a_insert_room, state_q == satq_pkg::ST_INSERT, !full, "insert into full queue")
  `SATQ_ASSERT_NEXT(a_cancel_keeps, state_q == satq_pkg::ST_CANCEL, $stable(occ_w), "cancel moved slots")

endmodule

>>> hdl/satq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted alarm timer queue cell
// One queue slot. Cell 0 is the due end; later alarms sit in higher cells.
// ----------------------------------------------------------------------------
module satq_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  satq_pkg::cell_ctl_t ctl_i,
  input  satq_pkg::entry_t    lower_i,
  input  logic                lower_le_i,
  input  satq_pkg::entry_t    upper_i,
  input  logic                token_i,
  output satq_pkg::entry_t    entry_o,
  output logic                le_o,
  output logic                token_o
);

  logic                       occ_q, occ_d;
  logic                       valid_q, valid_d;
  logic                       token_q;
  logic [satq_pkg::SessW-1:0] sess_q, sess_d;
  logic [satq_pkg::TimeW-1:0] due_q, due_d;
  logic                       hit;

  assign entry_o = '{occ: occ_q, valid: valid_q, sess: sess_q, due: due_q};

  // This slot holds an alarm due no later than the one being inserted.
  assign le_o = occ_q && (due_q <= ctl_i.due);

  // The cancel token stops at the first live alarm of the session.
  assign hit     = token_q && occ_q && valid_q && (sess_q == ctl_i.sess);
  assign token_o = token_q && !hit;

  // Next slot contents.
  always_comb begin
    occ_d   = occ_q;
    valid_d = valid_q;
    sess_d  = sess_q;
    due_d   = due_q;
    case (ctl_i.cmd)
      satq_pkg::CELL_INSERT: begin
        if (!le_o) begin
          if (lower_le_i) begin
            occ_d   = 1'b1;
            valid_d = 1'b1;
            sess_d  = ctl_i.sess;
            due_d   = ctl_i.due;
          end else if (lower_i.occ) begin
            occ_d   = lower_i.occ;
            valid_d = lower_i.valid;
            sess_d  = lower_i.sess;
            due_d   = lower_i.due;
          end
        end
      end
      satq_pkg::CELL_POP: begin
        occ_d   = upper_i.occ;
        valid_d = upper_i.valid;
        sess_d  = upper_i.sess;
        due_d   = upper_i.due;
      end
      default: begin
        if (hit) begin
          valid_d = 1'b0;
        end
      end
    endcase
  end

  // Occupancy, valid bit and cancel token.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q   <= 1'b0;
      valid_q <= 1'b0;
      token_q <= 1'b0;
    end else begin
      occ_q   <= occ_d;
      valid_q <= valid_d;
      token_q <= token_i;
    end
  end

  // Alarm payload.
  always_ff @(posedge clk_i) begin
    sess_q <= sess_d;
    due_q  <= due_d;
  end

endmodule
